// ===== rtl/png_ihdr_pkg.sv =====
// Constants, fault codes and the depth/color legality function of the PNG header checker.
package png_ihdr_pkg;

    localparam int unsigned IDX_W = 6;
    localparam int unsigned FAULT_W = 3;

    localparam logic [IDX_W-1:0] HDR_BYTES   = 6'd33;
    localparam logic [IDX_W-1:0] SIG_BYTES   = 6'd8;
    localparam logic [IDX_W-1:0] IDX_LENGTH  = 6'd11;
    localparam logic [IDX_W-1:0] IDX_TYPE    = 6'd15;
    localparam logic [IDX_W-1:0] IDX_WIDTH   = 6'd19;
    localparam logic [IDX_W-1:0] IDX_HEIGHT  = 6'd23;
    localparam logic [IDX_W-1:0] IDX_DEPTH   = 6'd24;
    localparam logic [IDX_W-1:0] IDX_COLOR   = 6'd25;
    localparam logic [IDX_W-1:0] IDX_COMPR   = 6'd26;
    localparam logic [IDX_W-1:0] IDX_FILTER  = 6'd27;
    localparam logic [IDX_W-1:0] IDX_INTERL  = 6'd28;

    localparam logic [31:0] IHDR_LEN = 32'd13;
    localparam logic [31:0] IHDR_TAG = 32'h4948_4452;

    localparam logic [30:0] WIDTH_RESET  = 31'd1024;
    localparam logic [30:0] HEIGHT_RESET = 31'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [FAULT_W-1:0] FAULT_NONE      = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_SHORT     = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_SIGNATURE = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_LEN_TYPE  = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_SIZE      = 3'd4;
    localparam logic [FAULT_W-1:0] FAULT_DEPTH     = 3'd5;
    localparam logic [FAULT_W-1:0] FAULT_FORMAT    = 3'd6;

    localparam logic [7:0] COLOR_GRAY       = 8'd0;
    localparam logic [7:0] COLOR_RGB        = 8'd2;
    localparam logic [7:0] COLOR_PALETTE    = 8'd3;
    localparam logic [7:0] COLOR_GRAY_ALPHA = 8'd4;
    localparam logic [7:0] COLOR_RGBA       = 8'd6;

    typedef logic [7:0] byte_t;

    function automatic byte_t sig_byte(input logic [2:0] pos);
        byte_t b;
        case (pos)
            3'd0: b = 8'h89;
            3'd1: b = 8'h50;
            3'd2: b = 8'h4E;
            3'd3: b = 8'h47;
            3'd4: b = 8'h0D;
            3'd5: b = 8'h0A;
            3'd6: b = 8'h1A;
            3'd7: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic depth_fits_color(input byte_t depth, input byte_t color);
        logic ok;
        case (color)
            COLOR_GRAY: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16};
            COLOR_RGB, COLOR_GRAY_ALPHA, COLOR_RGBA: ok = depth inside {8'd8, 8'd16};
            COLOR_PALETTE: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8};
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== rtl/png_ihdr_header_checker.sv =====
// Top level of the PNG signature and IHDR header checker.
//
// Input channel (s_valid/s_ready): one file byte per item, s_last_byte set on
// the final byte of the header read. Result channel (m_valid/m_ready): one item
// per flagged byte, m_header_ok and m_fault_code (first failing check, or too
// short when fewer than 33 bytes were taken).
// Configuration: cfg_wr_en writes cfg_data into the expected width (index 0)
// or height (index 1); write only while idle.
// Throughput: one byte per cycle unless a result stalls. The checks run between the
// byte input and the header state registers; the result sits in an output register
// in the cycle after the flagged byte is accepted.
// A held result stops the input: s_ready stays high while the output
// register is empty or being taken, so only a result stalled by m_ready
// blocks the next item.
// Reset: expected sizes return to 1024 x 480, the byte count and fault
// state clear, no result is pending. After each flagged byte the block rearms.
module png_ihdr_header_checker
    import png_ihdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_header_ok,
    output logic [2:0]  m_fault_code
);

    logic [30:0]        width_reg;
    logic [30:0]        height_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [31:0]        acc_reg, acc_next;
    byte_t              depth_reg, depth_next;
    logic               m_valid_reg;
    logic               ok_reg;
    logic [FAULT_W-1:0] code_reg, code_next;
    logic [FAULT_W-1:0] check_fault;
    logic [31:0]        shifted;
    logic               accept;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_header_ok  = ok_reg;
    assign m_fault_code = code_reg;

    always_comb begin
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        depth_next  = depth_reg;
        check_fault = FAULT_NONE;
        shifted     = {acc_reg[23:0], s_data_byte};
        if (idx_reg < HDR_BYTES) begin
            acc_next = shifted;
            idx_next = idx_reg + 6'd1;
            if (idx_reg < SIG_BYTES) begin
                if (s_data_byte != sig_byte(idx_reg[2:0])) check_fault = FAULT_SIGNATURE;
            end else begin
                case (idx_reg)
                    IDX_LENGTH: if (shifted != IHDR_LEN) check_fault = FAULT_LEN_TYPE;
                    IDX_TYPE:   if (shifted != IHDR_TAG) check_fault = FAULT_LEN_TYPE;
                    IDX_WIDTH:  if (shifted != {1'b0, width_reg}) check_fault = FAULT_SIZE;
                    IDX_HEIGHT: if (shifted != {1'b0, height_reg}) check_fault = FAULT_SIZE;
                    IDX_DEPTH:  depth_next = s_data_byte;
                    IDX_COLOR: begin
                        if (!depth_fits_color(depth_reg, s_data_byte)) check_fault = FAULT_DEPTH;
                    end
                    IDX_COMPR, IDX_FILTER: begin
                        if (s_data_byte != 8'd0) check_fault = FAULT_FORMAT;
                    end
                    IDX_INTERL: if (s_data_byte > 8'd1) check_fault = FAULT_FORMAT;
                    default: check_fault = FAULT_NONE;
                endcase
            end
        end
        fault_next = (fault_reg == FAULT_NONE) ? check_fault : fault_reg;
        code_next  = (idx_next < HDR_BYTES) ? FAULT_SHORT : fault_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WIDTH) begin
                width_reg <= cfg_data;
            end else begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            fault_reg   <= FAULT_NONE;
            acc_reg     <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_last_byte) begin
                    idx_reg   <= '0;
                    fault_reg <= FAULT_NONE;
                    acc_reg   <= '0;
                    depth_reg <= '0;
                end else begin
                    idx_reg   <= idx_next;
                    fault_reg <= fault_next;
                    acc_reg   <= acc_next;
                    depth_reg <= depth_next;
                end
            end
            if (accept && s_last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            code_reg <= code_next;
            ok_reg   <= (code_next == FAULT_NONE);
        end
    end

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> m_valid_reg)
        else $error("no result after flagged item");

    a_rearm_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> idx_reg == '0 && fault_reg == FAULT_NONE)
        else $error("state not rearmed after flagged item");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= HDR_BYTES)
        else $error("byte index past header length");

    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (ok_reg == (code_reg == FAULT_NONE)))
        else $error("header_ok disagrees with fault_code");

    a_short_before_full: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte && idx_reg < (HDR_BYTES - 6'd1) |=> code_reg == FAULT_SHORT)
        else $error("short header not reported");

endmodule

// ===== bench/png_ihdr_verdict_checker.sv =====
// Checker for the PNG header checker: predicts each verdict from the accepted bytes and compares.
`timescale 1ns / 100ps

module png_ihdr_verdict_checker
    import png_ihdr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [30:0]       cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_header_ok,
    input  logic [2:0]        m_fault_code,
    output int unsigned       fail_count,
    output int unsigned       results_pending
);

    typedef struct packed {
        logic               ok;
        logic [FAULT_W-1:0] code;
    } verdict_t;

    localparam byte_t PNG_MAGIC [0:7] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};

    logic [30:0]        want_width;
    logic [30:0]        want_height;
    logic [IDX_W-1:0]   hdr_pos;
    logic [FAULT_W-1:0] early_fault;
    logic [31:0]        word_window;
    byte_t              depth_held;
    verdict_t           verdict_q[$];

    function automatic logic legal_depth(input byte_t depth, input byte_t color);
        logic pow_upto8;
        logic wide;
        logic ok;
        pow_upto8 = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) || (depth == 8'd8);
        wide      = (depth == 8'd8) || (depth == 8'd16);
        case (color)
            COLOR_GRAY:                              ok = pow_upto8 || (depth == 8'd16);
            COLOR_PALETTE:                           ok = pow_upto8;
            COLOR_RGB, COLOR_GRAY_ALPHA, COLOR_RGBA: ok = wide;
            default:                                 ok = 1'b0;
        endcase
        return ok;
    endfunction

    task automatic rearm_header();
        hdr_pos     = '0;
        early_fault = FAULT_NONE;
        word_window = '0;
        depth_held  = '0;
    endtask

    task automatic flag_fault(input logic [FAULT_W-1:0] code);
        if (early_fault == FAULT_NONE) begin
            early_fault = code;
        end
    endtask

    task automatic take_header_byte(input byte_t b, input logic last);
        verdict_t v;
        if (hdr_pos < HDR_BYTES) begin
            word_window = {word_window[23:0], b};
            if (hdr_pos < SIG_BYTES) begin
                if (b != PNG_MAGIC[hdr_pos[2:0]]) flag_fault(FAULT_SIGNATURE);
            end else begin
                case (hdr_pos)
                    IDX_LENGTH: if (word_window != IHDR_LEN) flag_fault(FAULT_LEN_TYPE);
                    IDX_TYPE:   if (word_window != IHDR_TAG) flag_fault(FAULT_LEN_TYPE);
                    IDX_WIDTH:  if (word_window != {1'b0, want_width}) flag_fault(FAULT_SIZE);
                    IDX_HEIGHT: if (word_window != {1'b0, want_height}) flag_fault(FAULT_SIZE);
                    IDX_DEPTH:  depth_held = b;
                    IDX_COLOR:  if (!legal_depth(depth_held, b)) flag_fault(FAULT_DEPTH);
                    IDX_COMPR, IDX_FILTER: if (b != 8'd0) flag_fault(FAULT_FORMAT);
                    IDX_INTERL: if (b > 8'd1) flag_fault(FAULT_FORMAT);
                    default: ;
                endcase
            end
            hdr_pos = hdr_pos + 1'b1;
        end
        if (last) begin
            v.code = (hdr_pos < HDR_BYTES) ? FAULT_SHORT : early_fault;
            v.ok   = (v.code == FAULT_NONE);
            verdict_q.push_back(v);
            rearm_header();
        end
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            want_width  = WIDTH_RESET;
            want_height = HEIGHT_RESET;
            rearm_header();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual ok %0b fault %0d",
                             $time, m_header_ok, m_fault_code);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_header_ok !== want.ok) begin
                        fail_count++;
                        $display("%0t: header_ok expected %0b actual %0b",
                                 $time, want.ok, m_header_ok);
                    end
                    if (m_fault_code !== want.code) begin
                        fail_count++;
                        $display("%0t: fault_code expected %0d actual %0d",
                                 $time, want.code, m_fault_code);
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_header_byte(s_data_byte, s_last_byte);
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_WIDTH) begin
                    want_width = cfg_data;
                end else begin
                    want_height = cfg_data;
                end
            end
        end
        results_pending = verdict_q.size();
    end

endmodule

// ===== bench/tb_png_ihdr_header_checker.sv =====
// Testbench top for the PNG header checker: drives header byte streams and gives the verdict.
`timescale 1ns / 100ps

module tb_png_ihdr_header_checker;
    import png_ihdr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_BYTES = 160;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [30:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_header_ok;
    logic [2:0]  m_fault_code;

    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned cycle_count;
    int unsigned bytes_sent;

    byte_t       hdr [0:39];
    logic [30:0] cur_w;
    logic [30:0] cur_h;
    bit          calm_tx;
    bit          calm_rx;
    bit          hold_long;

    png_ihdr_header_checker dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_header_ok  (m_header_ok),
        .m_fault_code (m_fault_code)
    );

    png_ihdr_verdict_checker u_verdict (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_header_ok     (m_header_ok),
        .m_fault_code    (m_fault_code),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_png_ihdr_header_checker NOT OK");
            $finish;
        end
    end

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic put_byte(input byte_t b, input logic last);
        int unsigned gap;
        gap = pause_len(calm_tx);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = b;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic place_word(input int unsigned pos, input logic [31:0] v);
        for (int i = 0; i < 4; i++) begin
            hdr[pos + i] = v[31 - 8*i -: 8];
        end
    endtask

    task automatic set_header(input logic [31:0] w, input logic [31:0] h, input byte_t depth,
                              input byte_t color, input byte_t interl);
        place_word(0, 32'h8950_4E47);
        place_word(4, 32'h0D0A_1A0A);
        place_word(8, IHDR_LEN);
        place_word(12, IHDR_TAG);
        place_word(16, w);
        place_word(20, h);
        hdr[24] = depth;
        hdr[25] = color;
        hdr[26] = 8'd0;
        hdr[27] = 8'd0;
        hdr[28] = interl;
        for (int i = 29; i < 40; i++) begin
            hdr[i] = byte_t'($urandom);
        end
    endtask

    task automatic send_run(input int unsigned len, input logic flag);
        for (int unsigned i = 0; i < len; i++) begin
            put_byte(hdr[i], flag && (i == len - 1));
        end
    endtask

    task automatic pick_format(output byte_t depth, output byte_t color);
        case ($urandom_range(0, 4))
            0: begin
                color = COLOR_GRAY;
                depth = 8'd1 << $urandom_range(0, 4);
            end
            1: begin
                color = COLOR_PALETTE;
                depth = 8'd1 << $urandom_range(0, 3);
            end
            2: color = COLOR_RGB;
            3: color = COLOR_GRAY_ALPHA;
            default: color = COLOR_RGBA;
        endcase
        if (color != COLOR_GRAY && color != COLOR_PALETTE) begin
            depth = $urandom_range(0, 1) ? 8'd16 : 8'd8;
        end
    endtask

    task automatic random_header();
        byte_t       depth;
        byte_t       color;
        int unsigned kind;
        int unsigned len;
        logic        flag;
        pick_format(depth, color);
        set_header({1'b0, cur_w}, {1'b0, cur_h}, depth, color, byte_t'($urandom_range(0, 1)));
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            repeat ((kind < 20) ? 1 : 2) begin
                hdr[$urandom_range(0, 32)] ^= byte_t'($urandom_range(1, 255));
            end
        end else if (kind < 36) begin
            hdr[24] = byte_t'($urandom);
            hdr[25] = byte_t'($urandom_range(0, 7));
        end else if (kind < 40) begin
            hdr[26 + $urandom_range(0, 2)] = byte_t'($urandom_range(0, 3));
        end
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = 33;
        end else if (kind < 82) begin
            len = $urandom_range(34, 40);
        end else if (kind < 94) begin
            len = $urandom_range(1, 32);
        end else begin
            for (int i = 0; i < 40; i++) begin
                hdr[i] = byte_t'($urandom);
            end
            len = $urandom_range(1, 40);
        end
        flag = ($urandom_range(0, 19) != 0);
        calm_tx = ($urandom_range(0, 7) == 0);
        send_run(len, flag);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        int unsigned len;
        logic        flag;
        int unsigned start;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_WIDTH;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last_byte = 1'b0;
        m_ready     = 1'b0;
        cur_w       = WIDTH_RESET;
        cur_h       = HEIGHT_RESET;
        calm_tx     = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int n = 0; n < 15; n++) begin
            set_header({1'b0, cur_w}, {1'b0, cur_h}, 8'd8, COLOR_RGB, 8'd0);
            len  = 33;
            flag = 1'b1;
            case (n)
                0: begin
                    hdr[0] = 8'h00;
                    len    = 1;
                end
                1: begin
                    hdr[24] = 8'd1;
                    hdr[25] = COLOR_GRAY;
                    hdr[28] = 8'd1;
                end
                2: begin
                    hdr[24] = 8'd16;
                    hdr[25] = COLOR_RGBA;
                    for (int i = 33; i < 36; i++) hdr[i] = 8'hFF;
                    len = 36;
                end
                3: begin
                    hdr[0]  = 8'h00;
                    hdr[24] = 8'd4;
                    hdr[25] = COLOR_PALETTE;
                    len     = 32;
                end
                4: begin
                    hdr[0]  = 8'hFF;
                    hdr[25] = 8'd7;
                end
                5:  hdr[11] = 8'd14;
                6:  hdr[15] = 8'h58;
                7:  hdr[19] = hdr[19] + 8'd1;
                8:  hdr[23] = hdr[23] ^ 8'h01;
                9:  hdr[25] = 8'hFF;
                10: begin
                    hdr[24] = 8'd16;
                    hdr[25] = COLOR_PALETTE;
                end
                11: hdr[26] = 8'd1;
                12: hdr[27] = 8'h80;
                13: hdr[28] = 8'd2;
                default: begin
                    hdr[24] = 8'd16;
                    hdr[25] = COLOR_GRAY_ALPHA;
                    flag    = 1'b0;
                end
            endcase
            send_run(len, flag);
            if (!flag) put_byte(8'h5A, 1'b1);
        end

        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    cur_w = 31'd1;
                    cur_h = 31'd1;
                end
                1: begin
                    cur_w = 31'h7FFF_FFFF;
                    cur_h = 31'h7FFF_FFFF;
                end
                2: begin
                    cur_w = '0;
                    cur_h = '0;
                end
                3: begin
                    cur_w = 31'($urandom_range(1, 4096));
                    cur_h = 31'($urandom_range(1, 4096));
                end
                4: begin
                    cur_w = WIDTH_RESET;
                    cur_h = HEIGHT_RESET;
                end
                default: begin
                    cur_w = 31'($urandom_range(1, 32'h7FFF_FFFF));
                    cur_h = 31'($urandom_range(1, 32'h7FFF_FFFF));
                end
            endcase
            write_reg(REG_WIDTH, cur_w);
            write_reg(REG_HEIGHT, cur_h);
            if (ph == 1) hold_long = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                random_header();
            end
            put_byte(byte_t'($urandom), 1'b1);
        end

        drain_results();
        if (fail_count == 0) begin
            $display("tb_png_ihdr_header_checker OK");
        end else begin
            $display("tb_png_ihdr_header_checker NOT OK");
        end
        $finish;
    end

    initial begin
        int unsigned gap;
        hold_long = 1'b0;
        calm_rx   = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                hold_long = 1'b0;
                m_ready   = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if ($urandom_range(0, 7) == 0) calm_rx = !calm_rx;
            gap = pause_len(calm_rx);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

endmodule
